/* rtl/first_fit_region_allocator_core_defines.svh */
// assertion macros for the region allocator
`ifndef FIRST_FIT_REGION_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_REGION_ALLOCATOR_CORE_DEFINES_SVH
`define FFRA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FFRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/ffra_pkg.sv */
// types and constants of the region allocator
`timescale 1ns / 1ps
`default_nettype none
package ffra_pkg;
    localparam logic [1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [1:0] FUNC_FREE    = 2'd1;
    localparam logic [1:0] FUNC_COMPACT = 2'd2;
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_MOVE    = 2'd2;
    localparam logic [31:0] TOTAL_SIZE_RESET = 32'd16777216;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_SHIFT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [31:0] offset;
        logic [31:0] length;
        logic [15:0] owner;
    } entry_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] offset;
        logic [31:0] old_offset;
        logic [31:0] move_length;
        logic [15:0] moved_id;
        logic        last;
    } result_t;
endpackage
`default_nettype wire

/* rtl/ffra_table_ram.sv */
// region table memory, one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module ffra_table_ram #(
    parameter int DEPTH = 32,
    parameter int AW = 5
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire ffra_pkg::entry_t wdata,
    input  wire logic [AW-1:0]    raddr,
    output ffra_pkg::entry_t      rdata
);
    ffra_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* rtl/first_fit_region_allocator_core.sv */
// Region allocator keeping a sorted table of (offset, length, owner) in one
// synchronous memory. One operation at a time; apart from an allocate into a
// full table, which fails at once, each walks the table with one memory read
// per entry. When allocate inserts, the scan stops at the insert position and
// the shift walks the entries above it, so the two cover the table once. Free
// compacts the table in the same pass; compact stalls while the sink holds back
// a move beat. The next beat is accepted the cycle after the last result beat
// leaves. The number of regions in the table is at most MAX_REGIONS. The single
// memory read port sets the pace.
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_region_allocator_core_defines.svh"
module first_fit_region_allocator_core #(
    parameter int MAX_REGIONS = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [31:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // region_id[15:0], byte_count[47:16]
    input  wire logic [47:0]  s_tdata,
    // func[1:0]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // offset[31:0], old_offset[63:32], move_length[95:64], moved_id[111:96]
    output logic [111:0]      m_tdata,
    // status[1:0]
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);
    localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_REGIONS);

    ffra_pkg::state_t state_reg, state_next;
    logic [31:0]   total_size_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rd_reg, rd_next;     // read index
    logic [CW-1:0] wr_reg, wr_next;     // write index (free), position (alloc)
    logic [32:0]   cursor_reg, cursor_next;
    logic [1:0]    func_reg;
    logic [15:0]   id_reg;
    logic [31:0]   bytes_reg;
    logic          found_reg, found_next;
    logic          done_next;
    ffra_pkg::result_t res_reg, res_next;
    logic          res_valid_reg, res_valid_next;

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    ffra_pkg::entry_t wdata, rdata;
    logic             accept;

    ffra_table_ram #(.DEPTH(MAX_REGIONS), .AW(AW)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign s_tready = (state_reg == ffra_pkg::S_IDLE) && !res_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = res_valid_reg;
    assign m_tuser  = res_reg.status;
    assign m_tlast  = res_reg.last;
    assign m_tdata  = {res_reg.moved_id, res_reg.move_length, res_reg.old_offset,
                       res_reg.offset};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_size_reg <= ffra_pkg::TOTAL_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            total_size_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffra_pkg::S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= s_tuser;
            id_reg    <= s_tdata[15:0];
            bytes_reg <= s_tdata[47:16];
        end
        rd_reg     <= rd_next;
        wr_reg     <= wr_next;
        cursor_reg <= cursor_next;
        found_reg  <= found_next;
        res_reg    <= res_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ffra_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = ffra_pkg::S_READ;
                end
            end
            ffra_pkg::S_READ:
            begin
                state_next = ffra_pkg::S_SCAN;
            end
            ffra_pkg::S_SCAN:
            begin
                if (done_next)
                begin
                    state_next = found_next && func_reg == ffra_pkg::FUNC_ALLOC
                                 ? ffra_pkg::S_SHIFT : ffra_pkg::S_OUT;
                end
            end
            ffra_pkg::S_SHIFT:
            begin
                if (wr_reg == rd_reg)
                begin
                    state_next = ffra_pkg::S_OUT;
                end
            end
            ffra_pkg::S_OUT:
            begin
                if (!res_valid_reg)
                begin
                    state_next = ffra_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ffra_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        logic [32:0] ro;
        logic [32:0] gap;
        logic        stall;
        logic        in_range;
        count_next     = count_reg;
        rd_next        = rd_reg;
        wr_next        = wr_reg;
        cursor_next    = cursor_reg;
        found_next     = found_reg;
        done_next      = 1'b0;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !m_tready;
        we             = 1'b0;
        waddr          = rd_reg[AW-1:0];
        wdata          = rdata;
        raddr          = rd_reg[AW-1:0];
        ro             = {1'b0, rdata.offset};
        gap            = (ro >= cursor_reg) ? ro - cursor_reg : 33'd0;
        stall          = res_valid_reg && !m_tready;
        in_range       = rd_reg < count_reg;
        unique case (state_reg)
            ffra_pkg::S_IDLE:
            begin
                rd_next     = '0;
                wr_next     = '0;
                cursor_next = '0;
                found_next  = 1'b0;
                raddr       = '0;
            end
            ffra_pkg::S_READ:
            begin
                // rdata holds entry 0 next cycle
                raddr = rd_reg[AW-1:0];
            end
            ffra_pkg::S_SCAN:
            begin
                unique case (func_reg)
                    ffra_pkg::FUNC_ALLOC:
                    begin
                        if (count_reg >= MAXC)
                        begin
                            done_next = 1'b1;
                        end
                        else if (in_range && gap >= {1'b0, bytes_reg})
                        begin
                            found_next = 1'b1;
                            done_next  = 1'b1;
                            wr_next    = rd_reg;
                            rd_next    = count_reg;
                        end
                        else if (in_range)
                        begin
                            cursor_next = ro + {1'b0, rdata.length};
                            rd_next     = rd_reg + 1'b1;
                            raddr       = AW'(rd_reg + 1'b1);
                        end
                        else
                        begin
                            done_next = 1'b1;
                            if (cursor_reg + {1'b0, bytes_reg} <= {1'b0, total_size_reg})
                            begin
                                found_next = 1'b1;
                                wr_next    = count_reg;
                                rd_next    = count_reg;
                            end
                        end
                        if (done_next && found_next)
                        begin
                            // start shift at top: read entry count-1
                            raddr = AW'(count_reg - 1'b1);
                        end
                    end
                    ffra_pkg::FUNC_FREE:
                    begin
                        if (in_range)
                        begin
                            if (rdata.owner != id_reg)
                            begin
                                we      = 1'b1;
                                waddr   = wr_reg[AW-1:0];
                                wr_next = wr_reg + 1'b1;
                            end
                            rd_next = rd_reg + 1'b1;
                            raddr   = AW'(rd_reg + 1'b1);
                        end
                        else
                        begin
                            count_next = wr_reg;
                            done_next  = 1'b1;
                        end
                    end
                    ffra_pkg::FUNC_COMPACT:
                    begin
                        if (!in_range)
                        begin
                            done_next = 1'b1;
                        end
                        else if (!stall)
                        begin
                            if (ro != {1'b0, cursor_reg[31:0]})
                            begin
                                we                      = 1'b1;
                                wdata.offset            = cursor_reg[31:0];
                                res_next.status         = ffra_pkg::ST_MOVE;
                                res_next.offset         = cursor_reg[31:0];
                                res_next.old_offset     = rdata.offset;
                                res_next.move_length    = rdata.length;
                                res_next.moved_id       = rdata.owner;
                                res_next.last           = 1'b0;
                                res_valid_next          = 1'b1;
                            end
                            cursor_next = {1'b0, cursor_reg[31:0]} + {1'b0, rdata.length};
                            rd_next     = rd_reg + 1'b1;
                            raddr       = AW'(rd_reg + 1'b1);
                        end
                    end
                    default:
                    begin
                        done_next = 1'b1;
                    end
                endcase
            end
            ffra_pkg::S_SHIFT:
            begin
                // rdata holds entry rd_reg-1; write it to rd_reg
                we    = 1'b1;
                waddr = rd_reg[AW-1:0];
                if (wr_reg == rd_reg)
                begin
                    wdata.offset = cursor_reg[31:0];
                    wdata.length = bytes_reg;
                    wdata.owner  = id_reg;
                    count_next   = count_reg + 1'b1;
                end
                else
                begin
                    rd_next = rd_reg - 1'b1;
                    raddr   = AW'(rd_reg - 2'd2);
                end
            end
            ffra_pkg::S_OUT:
            begin
                if (!res_valid_reg)
                begin
                    res_valid_next       = 1'b1;
                    res_next.status      = ffra_pkg::ST_OK;
                    res_next.offset      = '0;
                    res_next.old_offset  = '0;
                    res_next.move_length = '0;
                    res_next.moved_id    = '0;
                    res_next.last        = 1'b1;
                    if (func_reg == ffra_pkg::FUNC_ALLOC)
                    begin
                        if (found_reg)
                        begin
                            res_next.offset = cursor_reg[31:0];
                        end
                        else
                        begin
                            res_next.status = ffra_pkg::ST_NOSPACE;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    `FFRA_ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, count_reg <= MAXC,
        "region count beyond table depth")
    `FFRA_ASSERT_IMPL(a_grow_one, clk, rst_n, count_reg > $past(count_reg),
        count_reg == $past(count_reg) + 1'b1, "table grew by more than one entry")
    `FFRA_ASSERT_IMPL(a_ready_idle, clk, rst_n, s_tready,
        state_reg == ffra_pkg::S_IDLE && !m_tvalid, "ready while busy")
endmodule
`default_nettype wire
